### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ZMH_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ZMH_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Same-cycle implication that is also checked around reset.
`define ZMH_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error(msg);

`endif

### hw/rtl/zmh_pkg.sv
`default_nettype none

package zmh_pkg;

   localparam int unsigned GARB_W = 18;

   typedef enum logic [1:0] {
      EV_BYTE    = 2'd0,
      EV_TIMEOUT = 2'd1,
      EV_CARRIER = 2'd2,
      EV_NONE    = 2'd3
   } zmh_event_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_CRC     = 3'd1,
      ST_GARBAGE = 3'd2,
      ST_CANCEL  = 3'd3,
      ST_TIMEOUT = 3'd4,
      ST_CARRIER = 3'd5,
      ST_BAD_ESC = 3'd6
   } zmh_status_type;

   typedef enum logic [1:0] {
      FK_BIN16 = 2'd0,
      FK_HEX16 = 2'd1,
      FK_BIN32 = 2'd2
   } zmh_frame_type;

   typedef struct packed {
      zmh_event_type ev;
      logic [7:0]    data;
   } zmh_item_type;

   typedef struct packed {
      zmh_status_type status;
      zmh_frame_type  kind;
      logic [7:0]     htype;
      logic [31:0]    hdata;
   } zmh_result_type;

   localparam logic [7:0]  CH_PAD  = 8'h2A;
   localparam logic [7:0]  CH_DLE  = 8'h18;
   localparam logic [7:0]  CH_XON  = 8'h11;
   localparam logic [7:0]  CH_XOFF = 8'h13;
   localparam logic [7:0]  CH_CR   = 8'h0D;
   localparam logic [7:0]  CH_LF   = 8'h0A;
   localparam logic [7:0]  CH_KIND_A = 8'h41;
   localparam logic [7:0]  CH_KIND_B = 8'h42;
   localparam logic [7:0]  CH_KIND_C = 8'h43;
   localparam logic [7:0]  CH_ABORT  = 8'h6B;   // 'k'
   localparam logic [7:0]  CH_ESC_H  = 8'h68;   // 'h'
   localparam logic [7:0]  CH_ESC_L  = 8'h6C;   // 'l' -> 0x7F
   localparam logic [7:0]  CH_ESC_M  = 8'h6D;   // 'm' -> 0xFF
   localparam logic [7:0]  RUBOUT    = 8'h7F;
   localparam logic [7:0]  ALL_ONES8 = 8'hFF;

   localparam logic [15:0] CRC16_POLY    = 16'h1021;
   localparam logic [31:0] CRC32_POLY    = 32'hEDB88320;
   localparam logic [31:0] CRC32_INIT    = 32'hFFFFFFFF;
   localparam logic [31:0] CRC32_RESIDUE = 32'hDEBB20E3;

   localparam logic [GARB_W-1:0] GARBAGE_RESET = 18'd2400;
   localparam logic [2:0]        CANCEL_RESET  = 3'd5;

   function automatic logic [15:0] crc16_add(input logic [15:0] crc, input logic [7:0] v);
      logic [15:0] c;
      c = crc ^ {v, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC16_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

   function automatic logic [31:0] crc32_add(input logic [31:0] crc, input logic [7:0] v);
      logic [31:0] c;
      c = crc ^ {24'h000000, v};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ({1'b0, c[31:1]} ^ CRC32_POLY) : {1'b0, c[31:1]};
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/zmh_in_reg.sv
`default_nettype none

module zmh_in_reg
   import zmh_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [1:0]   req_tuser,
   input  wire logic [7:0]   req_tdata,
   input  wire logic         take,       // core consumes the held item
   output logic              item_valid,
   output zmh_item_type      item
);

   logic         valid_ff;
   logic         valid_in;
   zmh_item_type item_ff;

   assign req_tready = !valid_ff || take;
   assign valid_in   = (req_tvalid && req_tready) || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_tvalid && req_tready) begin
         item_ff.ev   <= zmh_event_type'(req_tuser);
         item_ff.data <= req_tdata;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

### hw/rtl/zmh_core.sv
`default_nettype none

module zmh_core
   import zmh_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              take,
   input  wire zmh_item_type      item,
   input  wire logic [GARB_W-1:0] max_garbage,
   output logic                   res_valid,
   output zmh_result_type         result
);

   typedef enum logic [3:0] {
      PH_HUNT    = 4'd0,
      PH_CANWAIT = 4'd1,
      PH_SPLAT   = 4'd2,
      PH_KIND    = 4'd3,
      PH_BIN     = 4'd4,
      PH_ESC     = 4'd5,
      PH_CAN1    = 4'd6,
      PH_CAN2    = 4'd7,
      PH_CAN3    = 4'd8,
      PH_HEXHI   = 4'd9,
      PH_HEXLO   = 4'd10,
      PH_TRAIL1  = 4'd11,
      PH_TRAIL2  = 4'd12
   } phase_type;

   phase_type         ph_ff, ph_in;
   logic [3:0]        idx_ff, idx_in;
   logic [15:0]       c16_ff, c16_in;
   logic [31:0]       c32_ff, c32_in;
   logic [31:0]       data_ff, data_in;
   logic [7:0]        type_ff, type_in;
   logic [GARB_W-1:0] garb_ff, garb_in;
   logic [2:0]        canc_ff, canc_in;
   logic [3:0]        nib_ff, nib_in;
   zmh_frame_type     kind_ff, kind_in;

   logic [7:0]     b;
   logic [7:0]     c;          // 7-bit masked byte
   logic           drop;
   logic           is_dig;
   logic [3:0]     dig;
   logic           emit;
   zmh_status_type emit_st;
   logic           restart;
   logic           to_trail;
   logic           garb_ev;
   logic [7:0]     garb_c;
   logic           can_ev;
   phase_type      can_next;
   logic           acc_en;
   logic [7:0]     acc_val;
   logic [3:0]     idx_inc;
   logic [3:0]     total;
   logic           good;

   assign b = item.data;
   assign c = {1'b0, item.data[6:0]};

   // line filter: flow control and most control characters are dropped
   assign drop = (c == CH_XON) || (c == CH_XOFF) ||
                 ((c[6:5] == 2'b00) && (c != CH_CR) && (c != CH_LF) && (c != CH_DLE));

   always_comb begin
      is_dig = 1'b0;
      dig    = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         is_dig = 1'b1;
         dig    = c[3:0];
      end else if (c >= 8'h61 && c <= 8'h66) begin
         is_dig = 1'b1;
         dig    = c[3:0] + 4'd9;
      end
   end

   assign idx_inc = idx_ff + 4'd1;
   assign total   = (kind_ff == FK_BIN32) ? 4'd9 : 4'd7;

   always_comb begin
      ph_in    = ph_ff;
      idx_in   = idx_ff;
      c16_in   = c16_ff;
      c32_in   = c32_ff;
      data_in  = data_ff;
      type_in  = type_ff;
      garb_in  = garb_ff;
      canc_in  = canc_ff;
      nib_in   = nib_ff;
      kind_in  = kind_ff;
      emit     = 1'b0;
      emit_st  = ST_OK;
      restart  = 1'b0;
      to_trail = 1'b0;
      garb_ev  = 1'b0;
      garb_c   = b;
      can_ev   = 1'b0;
      can_next = PH_HUNT;
      acc_en   = 1'b0;
      acc_val  = b;
      good     = 1'b0;
      result   = '0;

      if (take && item.ev != EV_NONE) begin
         if (ph_ff == PH_TRAIL1 || ph_ff == PH_TRAIL2) begin
            if (item.ev == EV_CARRIER) begin
               emit    = 1'b1;
               emit_st = ST_CARRIER;
            end else if (item.ev == EV_BYTE && ph_ff == PH_TRAIL1 && b == CH_CR) begin
               ph_in = PH_TRAIL2;
            end else begin
               ph_in = PH_HUNT;
            end
         end else if (ph_ff == PH_CANWAIT) begin
            // raw byte after a lone CAN
            if (item.ev == EV_TIMEOUT) begin
               ph_in = PH_HUNT;
            end else if (item.ev == EV_CARRIER) begin
               emit    = 1'b1;
               emit_st = ST_CARRIER;
            end else if (b == CH_ABORT) begin
               emit    = 1'b1;
               emit_st = ST_BAD_ESC;
            end else if (b == CH_DLE) begin
               can_ev   = 1'b1;
               can_next = PH_HUNT;
            end else begin
               garb_ev = 1'b1;
               garb_c  = b;
            end
         end else if (item.ev == EV_TIMEOUT) begin
            emit    = 1'b1;
            emit_st = ST_TIMEOUT;
         end else if (item.ev == EV_CARRIER) begin
            emit    = 1'b1;
            emit_st = ST_CARRIER;
         end else begin
            unique case (ph_ff)
               PH_HUNT: begin
                  if (!drop) begin
                     if (c == CH_PAD) begin
                        canc_in = CANCEL_RESET;
                        ph_in   = PH_SPLAT;
                     end else if (c == CH_DLE) begin
                        can_ev   = 1'b1;
                        can_next = PH_CANWAIT;
                     end else begin
                        garb_ev = 1'b1;
                        garb_c  = c;
                     end
                  end
               end
               PH_SPLAT: begin
                  if (!drop) begin
                     if (c == CH_DLE) begin
                        ph_in = PH_KIND;
                     end else if (c != CH_PAD) begin
                        garb_ev = 1'b1;
                        garb_c  = c;
                     end
                  end
               end
               PH_KIND: begin
                  if (!drop) begin
                     if (c == CH_KIND_A || c == CH_KIND_B || c == CH_KIND_C) begin
                        kind_in = (c == CH_KIND_A) ? FK_BIN16 :
                                  (c == CH_KIND_B) ? FK_HEX16 : FK_BIN32;
                        idx_in  = 4'd0;
                        c16_in  = 16'h0000;
                        c32_in  = CRC32_INIT;
                        data_in = 32'h0;
                        ph_in   = (c == CH_KIND_B) ? PH_HEXHI : PH_BIN;
                     end else if (c == CH_DLE) begin
                        can_ev   = 1'b1;
                        can_next = PH_CANWAIT;
                     end else begin
                        garb_ev = 1'b1;
                        garb_c  = c;
                     end
                  end
               end
               PH_BIN: begin
                  if (b == CH_DLE) begin
                     ph_in = PH_ESC;
                  end else begin
                     acc_en  = 1'b1;
                     acc_val = b;
                  end
               end
               PH_ESC: begin
                  ph_in = PH_BIN;
                  if (b == CH_DLE) begin
                     ph_in = PH_CAN1;
                  end else if (b >= CH_ESC_H && b <= CH_ABORT) begin
                     emit    = 1'b1;
                     emit_st = ST_BAD_ESC;
                  end else if (b == CH_ESC_L) begin
                     acc_en  = 1'b1;
                     acc_val = RUBOUT;
                  end else if (b == CH_ESC_M) begin
                     acc_en  = 1'b1;
                     acc_val = ALL_ONES8;
                  end else if (b[6:5] == 2'b10) begin
                     acc_en  = 1'b1;
                     acc_val = b ^ 8'h40;
                  end else begin
                     emit    = 1'b1;
                     emit_st = ST_BAD_ESC;
                  end
               end
               PH_CAN1, PH_CAN2: begin
                  if (b != CH_DLE) begin
                     emit    = 1'b1;
                     emit_st = ST_CANCEL;
                  end else begin
                     ph_in = (ph_ff == PH_CAN1) ? PH_CAN2 : PH_CAN3;
                  end
               end
               PH_CAN3: begin
                  emit    = 1'b1;
                  emit_st = ST_CANCEL;
               end
               PH_HEXHI, PH_HEXLO: begin
                  if (!drop) begin
                     if (!is_dig) begin
                        emit    = 1'b1;
                        emit_st = ST_BAD_ESC;
                     end else if (ph_ff == PH_HEXHI) begin
                        nib_in = dig;
                        ph_in  = PH_HEXLO;
                     end else begin
                        ph_in   = PH_HEXHI;
                        acc_en  = 1'b1;
                        acc_val = {nib_ff, dig};
                     end
                  end
               end
               default: begin
                  restart = 1'b1;
               end
            endcase
         end

         // unexpected byte while hunting
         if (garb_ev) begin
            if (garb_ff <= 18'd1) begin
               emit    = 1'b1;
               emit_st = ST_GARBAGE;
            end else begin
               garb_in = garb_ff - 18'd1;
               if (garb_c != CH_DLE) begin
                  canc_in = CANCEL_RESET;
               end
               ph_in = PH_HUNT;
            end
         end

         if (can_ev) begin
            if (canc_ff <= 3'd1) begin
               emit    = 1'b1;
               emit_st = ST_CANCEL;
            end else begin
               canc_in = canc_ff - 3'd1;
               ph_in   = can_next;
            end
         end

         // one decoded header byte
         if (acc_en) begin
            if (kind_ff == FK_BIN32) begin
               c32_in = crc32_add(c32_ff, acc_val);
            end else begin
               c16_in = crc16_add(c16_ff, acc_val);
            end
            if (idx_ff == 4'd0) begin
               type_in = acc_val;
            end else if (idx_ff <= 4'd4) begin
               data_in = {acc_val, data_ff[31:8]};
            end
            idx_in = idx_inc;
            if (idx_inc >= total) begin
               good     = (kind_ff == FK_BIN32) ? (c32_in == CRC32_RESIDUE) : (c16_in == 16'h0);
               emit     = 1'b1;
               emit_st  = good ? ST_OK : ST_CRC;
               to_trail = good && (kind_ff == FK_HEX16);
            end
         end

         if (emit) begin
            result.status = emit_st;
            result.kind   = kind_ff;
            result.htype  = (emit_st == ST_OK) ? type_in : 8'h00;
            result.hdata  = (emit_st == ST_OK) ? data_in : 32'h0;
         end

         // new attempt with fresh counters
         if (emit || restart) begin
            ph_in   = to_trail ? PH_TRAIL1 : PH_HUNT;
            idx_in  = 4'd0;
            c16_in  = 16'h0000;
            c32_in  = CRC32_INIT;
            data_in = 32'h0;
            type_in = 8'h00;
            garb_in = max_garbage;
            canc_in = CANCEL_RESET;
            nib_in  = 4'd0;
            kind_in = FK_BIN16;
         end
      end
   end

   assign res_valid = emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff   <= PH_HUNT;
         idx_ff  <= 4'd0;
         c16_ff  <= 16'h0000;
         c32_ff  <= CRC32_INIT;
         data_ff <= 32'h0;
         type_ff <= 8'h00;
         garb_ff <= GARBAGE_RESET;
         canc_ff <= CANCEL_RESET;
         nib_ff  <= 4'd0;
         kind_ff <= FK_BIN16;
      end else begin
         ph_ff   <= ph_in;
         idx_ff  <= idx_in;
         c16_ff  <= c16_in;
         c32_ff  <= c32_in;
         data_ff <= data_in;
         type_ff <= type_in;
         garb_ff <= garb_in;
         canc_ff <= canc_in;
         nib_ff  <= nib_in;
         kind_ff <= kind_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/zmh_out_reg.sv
`default_nettype none

module zmh_out_reg
   import zmh_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           load_valid,   // a transfer is moving through the core
   input  wire logic           res_valid,
   input  wire zmh_result_type result,
   output logic                can_load,
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   output logic [4:0]          rsp_tuser,
   output logic [39:0]         rsp_tdata
);

   logic           valid_ff;
   zmh_result_type res_ff;

   assign can_load = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (can_load) begin
         valid_ff <= load_valid && res_valid;
      end
      if (can_load && load_valid && res_valid) begin
         res_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = {res_ff.kind, res_ff.status};
   assign rsp_tdata  = {res_ff.hdata, res_ff.htype};

endmodule

`default_nettype wire

### hw/rtl/zmodem_header_receiver.sv
`default_nettype none

// Channel   Dir  Ports          Fields (low bit up)
// req       in   req_t*         tuser: event_kind[1:0]; tdata: rx_byte[7:0]
// rsp       out  rsp_t*         tuser: status[2:0], frame_kind[4:3];
//                               tdata: header_type[7:0], header_data[39:8]
// csr       in   csr_we/wdata   max_garbage[17:0], write only
//
// One transfer per cycle sustained while rsp is not stalled. A req transfer lands
// in the input register; once the output register can load, its result (if
// any) lands in the output register and drives rsp_tvalid.
// The whole per-event step (filter, CRC-16 or CRC-32 byte update, phase change)
// is one combinational pass between the input and output registers.
// While a result waits on a stalled rsp the core holds its item; req_tready
// drops once the input register is full as well.
// Synchronous active-high reset; max_garbage returns to 2400.

module zmodem_header_receiver
   import zmh_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   // line events
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [1:0]   req_tuser,   // event_kind[1:0]
   input  wire logic [7:0]   req_tdata,   // rx_byte[7:0]
   // header results
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [4:0]        rsp_tuser,   // status[2:0], frame_kind[4:3]
   output logic [39:0]       rsp_tdata,   // header_type[7:0], header_data[39:8]
   // garbage limit register
   input  wire logic         csr_we,
   input  wire logic [17:0]  csr_wdata    // max_garbage[17:0]
);

   logic [GARB_W-1:0] max_garb_ff;
   logic              item_valid;
   zmh_item_type      item;
   logic              can_load;
   logic              take;
   logic              res_valid;
   zmh_result_type    result;

   // zero limit acts as one
   always_ff @(posedge clock) begin
      if (reset) begin
         max_garb_ff <= GARBAGE_RESET;
      end else if (csr_we) begin
         max_garb_ff <= (csr_wdata == 18'd0) ? 18'd1 : csr_wdata;
      end
   end

   assign take = item_valid && can_load;

   zmh_in_reg u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   zmh_core u_core (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .item        (item),
      .max_garbage (max_garb_ff),
      .res_valid   (res_valid),
      .result      (result)
   );

   zmh_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load_valid (item_valid),
      .res_valid  (res_valid),
      .result     (result),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

### hw/rtl/zmh_checker.sv
`default_nettype none

`include "assert_macros.svh"

module zmh_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [4:0]  rsp_tuser,
   input wire logic [39:0] rsp_tdata
);

   `ZMH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "rsp changed while stalled")

   `ZMH_ASSERT_NOW(a_fail_clears, clock, reset, rsp_tvalid && rsp_tuser[2:0] != 3'd0,
      rsp_tdata == 40'h0, "failed header carries type or data")

   `ZMH_ASSERT_NOW(a_codes, clock, reset, rsp_tvalid,
      rsp_tuser[2:0] != 3'd7 && rsp_tuser[4:3] != 2'd3, "unused status or kind code")

   `ZMH_ASSERT_NOW(a_garbage_nokind, clock, reset, rsp_tvalid && rsp_tuser[2:0] == 3'd2,
      rsp_tuser[4:3] == 2'd0, "garbage limit reported with a frame kind")

   `ZMH_ASSERT_ALWAYS(a_reset_idle, clock, $fell(reset), !rsp_tvalid,
      "rsp valid right after reset")

endmodule

bind zmodem_header_receiver zmh_checker u_zmh_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
